FILE: hw/rtl/gpp_pkg.sv
// ----------------------------------------------------------------------------
// gpp_pkg
// types and constants shared by the gossip packet parser
// ----------------------------------------------------------------------------
package gpp_pkg;

  localparam logic [1:0] OP_BYTE  = 2'd0;
  localparam logic [1:0] OP_TICK  = 2'd1;
  localparam logic [1:0] OP_QUERY = 2'd2;
  localparam logic [1:0] OP_SPARE = 2'd3;

  localparam logic [7:0] KIND_ALIVE    = 8'd1;
  localparam logic [7:0] KIND_RESPONSE = 8'd2;
  localparam logic [7:0] KIND_BYE      = 8'd3;

  localparam logic [31:0] KEY_TEMPO    = 32'h746d6c6e;
  localparam logic [31:0] KEY_ENDPOINT = 32'h6d657034;
  localparam logic [31:0] KEY_STST     = 32'h73747374;

  localparam logic [19:0] LIFETIME_RESET = 20'd15000;
  localparam logic [41:0] TEMPO_NUM      = 42'd3932160000000;
  localparam int          HEADER_LEN     = 20;
  localparam int          DIV_STEPS      = 42;

  localparam logic [7:0] SIG [8] = '{8'h5f, 8'h61, 8'h73, 8'h64,
                                     8'h70, 8'h5f, 8'h76, 8'h01};

  typedef struct packed {
    logic [1:0]  operation;
    logic [7:0]  data_byte;
    logic        end_of_packet;
    logic [31:0] now_ms;
    logic [2:0]  peer_index;
  } in_word_t;

  typedef struct packed {
    logic        packet_accepted;
    logic [41:0] bpm_q16;
    logic        playing;
    logic        start_stop_seen;
    logic [3:0]  peer_count;
    logic        endpoint_valid;
    logic [31:0] endpoint_ip;
    logic [15:0] endpoint_port;
  } out_word_t;

  typedef enum logic [2:0] {
    CMD_REPORT,
    CMD_HELLO,
    CMD_BYE,
    CMD_TEMPO,
    CMD_ENDPOINT,
    CMD_STST,
    CMD_TICK,
    CMD_QUERY
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t   kind;
    logic        emit;
    logic        accepted;
    logic [31:0] now;
    logic [63:0] id;
    logic [63:0] value;
    logic [2:0]  idx;
  } cmd_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN,
    ST_ACT,
    ST_FETCH,
    ST_WRITE,
    ST_EXPIRE,
    ST_DIV,
    ST_DONE
  } back_state_t;

endpackage

FILE: hw/rtl/gpp_fifo.sv
// ----------------------------------------------------------------------------
// gpp_fifo
// small show-ahead queue of words
// ----------------------------------------------------------------------------
module gpp_fifo #(
  parameter int WIDTH  = 8,
  parameter int ADDR_W = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);
  localparam int DEPTH = 1 << ADDR_W;

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [ADDR_W-1:0] wp_r, rp_r;
  logic [ADDR_W:0]   cnt_r;
  logic do_push, do_pop;

  assign full    = (cnt_r == (ADDR_W+1)'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wp_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) wp_r <= wp_r + 1'b1;
      if (do_pop) rp_r <= rp_r + 1'b1;
      if (do_push && !do_pop) cnt_r <= cnt_r + 1'b1;
      else if (do_pop && !do_push) cnt_r <= cnt_r - 1'b1;
    end
  end
endmodule

FILE: hw/rtl/gpp_front.sv
// ----------------------------------------------------------------------------
// gpp_front
// byte parser: header check, record framing, command generation
// ----------------------------------------------------------------------------
module gpp_front #(
  parameter int MAX_PACKET_BYTES = 65535
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             accept,
  input  gpp_pkg::in_word_t in_word,
  output logic             cmd_push,
  output gpp_pkg::cmd_t    cmd
);
  import gpp_pkg::*;

  logic [15:0] pos_r, pos_nxt;
  logic        good_r, good_nxt;
  logic [7:0]  kind_r, kind_nxt;
  logic [63:0] sid_r, sid_nxt;
  logic [31:0] key_r, key_nxt;
  logic [31:0] size_r, size_nxt;
  logic [16:0] off_r, off_nxt;
  logic [63:0] val_r, val_nxt;
  logic        is_byte, in_range, hdr_evt, rec_on, rec_done, last;
  logic        acc_flag;
  logic [3:0]  n;
  logic [16:0] off1;
  logic [7:0]  b;
  cmd_kind_t   rec_kind;
  logic        rec_act;
  logic [63:0] rec_value;

  assign b        = in_word.data_byte;
  assign is_byte  = accept && (in_word.operation == OP_BYTE);
  assign in_range = 32'(pos_r) < 32'(MAX_PACKET_BYTES);
  assign last     = is_byte && in_word.end_of_packet;

  always_comb begin
    good_nxt = good_r;
    kind_nxt = kind_r;
    sid_nxt  = sid_r;
    key_nxt  = key_r;
    size_nxt = size_r;
    val_nxt  = val_r;
    off_nxt  = off_r;
    pos_nxt  = pos_r;
    hdr_evt  = 1'b0;
    rec_on   = 1'b0;
    rec_done = 1'b0;
    off1     = off_r + 17'd1;
    if (is_byte && in_range) begin
      pos_nxt = pos_r + 16'd1;
      if (pos_r < 16'd8) begin
        if (b != SIG[pos_r[2:0]]) good_nxt = 1'b0;
      end else if (pos_r == 16'd8) begin
        kind_nxt = b;
      end else if (pos_r >= 16'd12 && pos_r < 16'(HEADER_LEN)) begin
        sid_nxt = {sid_r[55:0], b};
        hdr_evt = (pos_r == 16'(HEADER_LEN - 1)) && good_r &&
                  (kind_r == KIND_ALIVE || kind_r == KIND_RESPONSE ||
                   kind_r == KIND_BYE);
      end else if (pos_r >= 16'(HEADER_LEN) && good_r &&
                   (kind_r == KIND_ALIVE || kind_r == KIND_RESPONSE)) begin
        rec_on = 1'b1;
        if (off_r < 17'd4) key_nxt = {key_r[23:0], b};
        else if (off_r < 17'd8) size_nxt = {size_r[23:0], b};
        else if (off_r < 17'd16) val_nxt = {val_r[55:0], b};
        off_nxt  = off1;
        rec_done = (off1 >= 17'd8) && (33'(off1) == 33'(size_nxt) + 33'd8);
      end
    end
  end

  assign n = (size_nxt < 32'd8) ? size_nxt[3:0] : 4'd8;

  always_comb begin
    rec_act   = 1'b0;
    rec_kind  = CMD_REPORT;
    rec_value = '0;
    if (key_nxt == KEY_TEMPO && size_nxt >= 32'd8) begin
      rec_act   = 1'b1;
      rec_kind  = CMD_TEMPO;
      rec_value = val_nxt;
    end else if (key_nxt == KEY_ENDPOINT && size_nxt >= 32'd6) begin
      rec_act   = 1'b1;
      rec_kind  = CMD_ENDPOINT;
      rec_value = {16'd0, 32'(val_nxt >> {n - 4'd4, 3'b000}),
                   16'(val_nxt >> {n - 4'd6, 3'b000})};
    end else if (key_nxt == KEY_STST && size_nxt >= 32'd1) begin
      rec_act   = 1'b1;
      rec_kind  = CMD_STST;
      rec_value = {56'd0, 8'(val_nxt >> {n - 4'd1, 3'b000})};
    end
  end

  assign acc_flag = (pos_nxt >= 16'(HEADER_LEN)) && good_nxt &&
                    (kind_nxt == KIND_ALIVE || kind_nxt == KIND_RESPONSE ||
                     kind_nxt == KIND_BYE);

  always_comb begin
    cmd          = '0;
    cmd.kind     = CMD_REPORT;
    cmd.now      = in_word.now_ms;
    cmd.id       = sid_nxt;
    cmd.idx      = in_word.peer_index;
    cmd_push     = 1'b0;
    if (accept) begin
      unique case (in_word.operation)
        OP_BYTE: begin
          cmd.emit     = last;
          cmd.accepted = last && acc_flag;
          if (hdr_evt) begin
            cmd.kind = (kind_r == KIND_BYE) ? CMD_BYE : CMD_HELLO;
            cmd_push = 1'b1;
          end else if (rec_on && rec_done && rec_act) begin
            cmd.kind  = rec_kind;
            cmd.value = rec_value;
            cmd_push  = 1'b1;
          end
          if (last) cmd_push = 1'b1;
        end
        OP_TICK: begin
          cmd.kind = CMD_TICK;
          cmd.emit = 1'b1;
          cmd_push = 1'b1;
        end
        OP_QUERY: begin
          cmd.kind = CMD_QUERY;
          cmd.emit = 1'b1;
          cmd_push = 1'b1;
        end
        default: cmd_push = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || last) begin
      pos_r  <= '0;
      good_r <= 1'b1;
      kind_r <= '0;
      sid_r  <= '0;
      key_r  <= '0;
      size_r <= '0;
      off_r  <= '0;
      val_r  <= '0;
    end else begin
      pos_r  <= pos_nxt;
      good_r <= good_nxt;
      kind_r <= kind_nxt;
      sid_r  <= sid_nxt;
      if (rec_done) begin
        key_r  <= '0;
        size_r <= '0;
        off_r  <= '0;
        val_r  <= '0;
      end else begin
        key_r  <= key_nxt;
        size_r <= size_nxt;
        off_r  <= off_nxt;
        val_r  <= val_nxt;
      end
    end
  end
endmodule

FILE: hw/rtl/gpp_back.sv
// ----------------------------------------------------------------------------
// gpp_back
// command engine: peer table, expiry sweep, tempo divider, result build
// ----------------------------------------------------------------------------
module gpp_back #(
  parameter int PEER_SLOTS = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [19:0]       cfg_wdata,
  input  gpp_pkg::cmd_t     cmd,
  input  logic              cmd_empty,
  output logic              cmd_pop,
  input  logic              res_full,
  output logic              res_push,
  output gpp_pkg::out_word_t res
);
  import gpp_pkg::*;

  localparam int SW = (PEER_SLOTS > 1) ? $clog2(PEER_SLOTS) : 1;
  localparam int CW = $clog2(PEER_SLOTS + 1);

  logic [63:0] ids_r  [PEER_SLOTS];
  logic [31:0] exp_r  [PEER_SLOTS];
  logic [31:0] ip_r   [PEER_SLOTS];
  logic [15:0] port_r [PEER_SLOTS];
  logic        has_r  [PEER_SLOTS];

  back_state_t state_r, state_nxt;
  cmd_t        cur_r;
  logic [CW-1:0] i_r, total_r;
  logic [SW-1:0] slot_r, rd_idx;
  logic          found_r;
  logic [41:0]   tempo_r, quo_r, num_r;
  logic          playing_r, seen_r;
  logic [19:0]   life_r;
  logic          ev_r;
  logic [31:0]   eip_r;
  logic [15:0]   eport_r;
  logic [63:0]   mv_id_r;
  logic [31:0]   mv_exp_r, mv_ip_r;
  logic [15:0]   mv_port_r;
  logic          mv_has_r;
  logic [63:0]   rem_r, rem2;
  logic [5:0]    cnt_r;
  logic          start, i_live, hit, div_ge, tempo_pos;
  logic [63:0]   rd_id;
  logic [31:0]   rd_exp;
  logic [31:0]   age;
  logic          is_old;

  assign start     = !cmd_empty && !res_full;
  assign i_live    = i_r < total_r;
  assign rd_id     = ids_r[rd_idx];
  assign rd_exp    = exp_r[rd_idx];
  assign hit       = rd_id == cur_r.id;
  assign tempo_pos = (cmd.value != '0) && !cmd.value[63];
  assign rem2      = {rem_r[62:0], num_r[41]};
  assign div_ge    = rem2 >= cur_r.value;

  assign age    = cur_r.now - rd_exp;
  assign is_old = !age[31];

  always_comb begin
    unique case (state_r)
      ST_IDLE:  rd_idx = SW'(cmd.idx);
      ST_FETCH: rd_idx = SW'(total_r - CW'(1));
      default:  rd_idx = i_r[SW-1:0];
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          unique case (cmd.kind)
            CMD_HELLO, CMD_BYE, CMD_ENDPOINT: state_nxt = ST_SCAN;
            CMD_TEMPO: state_nxt = tempo_pos ? ST_DIV : ST_DONE;
            CMD_TICK:  state_nxt = ST_EXPIRE;
            default:   state_nxt = ST_DONE;
          endcase
        end
      end
      ST_SCAN: begin
        if (!i_live || hit) state_nxt = ST_ACT;
      end
      ST_ACT: begin
        state_nxt = (cur_r.kind == CMD_BYE && found_r) ? ST_FETCH : ST_DONE;
      end
      ST_FETCH: state_nxt = ST_WRITE;
      ST_WRITE: state_nxt = (cur_r.kind == CMD_TICK) ? ST_EXPIRE : ST_DONE;
      ST_EXPIRE: begin
        if (!i_live) state_nxt = ST_DONE;
        else if (is_old) state_nxt = ST_FETCH;
      end
      ST_DIV: begin
        if (cnt_r == 6'(DIV_STEPS - 1)) state_nxt = ST_DONE;
      end
      ST_DONE: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_pop  = (state_r == ST_IDLE) && start;
    res_push = (state_r == ST_DONE) && cur_r.emit;
    res.packet_accepted = cur_r.accepted;
    res.bpm_q16         = tempo_r;
    res.playing         = playing_r;
    res.start_stop_seen = seen_r;
    res.peer_count      = 4'(total_r);
    res.endpoint_valid  = ev_r;
    res.endpoint_ip     = eip_r;
    res.endpoint_port   = eport_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      total_r   <= '0;
      tempo_r   <= '0;
      playing_r <= 1'b0;
      seen_r    <= 1'b0;
      life_r    <= LIFETIME_RESET;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) life_r <= cfg_wdata;
      unique case (state_r)
        ST_IDLE: begin
          if (start) begin
            cur_r   <= cmd;
            i_r     <= '0;
            found_r <= 1'b0;
            ev_r    <= 1'b0;
            eip_r   <= '0;
            eport_r <= '0;
            rem_r   <= '0;
            quo_r   <= '0;
            num_r   <= TEMPO_NUM;
            cnt_r   <= '0;
            if (cmd.kind == CMD_QUERY &&
                32'(cmd.idx) < 32'(total_r) && has_r[rd_idx]) begin
              ev_r    <= 1'b1;
              eip_r   <= ip_r[rd_idx];
              eport_r <= port_r[rd_idx];
            end
            if (cmd.kind == CMD_STST) begin
              playing_r <= cmd.value[7:0] != 8'd0;
              seen_r    <= 1'b1;
            end
          end
        end
        ST_SCAN: begin
          if (i_live) begin
            if (hit) begin
              found_r <= 1'b1;
              slot_r  <= i_r[SW-1:0];
            end else begin
              i_r <= i_r + CW'(1);
            end
          end
        end
        ST_ACT: begin
          if (cur_r.kind == CMD_HELLO) begin
            if (found_r) begin
              exp_r[slot_r] <= cur_r.now + 32'(life_r);
            end else if (32'(total_r) < 32'(PEER_SLOTS)) begin
              ids_r[total_r[SW-1:0]]  <= cur_r.id;
              exp_r[total_r[SW-1:0]]  <= cur_r.now + 32'(life_r);
              ip_r[total_r[SW-1:0]]   <= '0;
              port_r[total_r[SW-1:0]] <= '0;
              has_r[total_r[SW-1:0]]  <= 1'b0;
              total_r <= total_r + CW'(1);
            end
          end else if (cur_r.kind == CMD_ENDPOINT && found_r) begin
            ip_r[slot_r]   <= cur_r.value[47:16];
            port_r[slot_r] <= cur_r.value[15:0];
            has_r[slot_r]  <= 1'b1;
          end
        end
        ST_FETCH: begin
          mv_id_r   <= rd_id;
          mv_exp_r  <= rd_exp;
          mv_ip_r   <= ip_r[rd_idx];
          mv_port_r <= port_r[rd_idx];
          mv_has_r  <= has_r[rd_idx];
        end
        ST_WRITE: begin
          ids_r[slot_r]  <= mv_id_r;
          exp_r[slot_r]  <= mv_exp_r;
          ip_r[slot_r]   <= mv_ip_r;
          port_r[slot_r] <= mv_port_r;
          has_r[slot_r]  <= mv_has_r;
          total_r <= total_r - CW'(1);
          if (cur_r.kind == CMD_BYE && total_r == CW'(1)) begin
            tempo_r   <= '0;
            playing_r <= 1'b0;
            seen_r    <= 1'b0;
          end
        end
        ST_EXPIRE: begin
          if (i_live) begin
            if (is_old) slot_r <= i_r[SW-1:0];
            else i_r <= i_r + CW'(1);
          end else if (total_r == '0) begin
            tempo_r   <= '0;
            playing_r <= 1'b0;
            seen_r    <= 1'b0;
          end
        end
        ST_DIV: begin
          num_r <= {num_r[40:0], 1'b0};
          cnt_r <= cnt_r + 6'd1;
          if (div_ge) begin
            rem_r <= rem2 - cur_r.value;
            quo_r <= {quo_r[40:0], 1'b1};
          end else begin
            rem_r <= rem2;
            quo_r <= {quo_r[40:0], 1'b0};
          end
          if (cnt_r == 6'(DIV_STEPS - 1)) tempo_r <= {quo_r[40:0], div_ge};
        end
        default: begin
        end
      endcase
    end
  end
endmodule

FILE: hw/rtl/tempo_gossip_packet_parser_core.sv
// ----------------------------------------------------------------------------
// tempo_gossip_packet_parser_core
// gossip packet parser with peer table, queue-style ports
// ----------------------------------------------------------------------------
// a word that yields a result passes from the front parser through the 4-word
//   command queue and the back engine's work (peer scan, expiry sweep or tempo
//   division) into the 2-word result queue
// throughput: bytes enter one per cycle while the 4-word command queue has room
// reset: synchronous rst_n clears queues, session state and lifetime (15000)
module tempo_gossip_packet_parser_core #(
  parameter int PEER_SLOTS       = 8,
  parameter int MAX_PACKET_BYTES = 65535
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  output logic               in_full,
  input  gpp_pkg::in_word_t  in_word,
  output logic               out_empty,
  input  logic               out_pop,
  output gpp_pkg::out_word_t out_word,
  input  logic               cfg_we,
  input  logic [19:0]        cfg_wdata
);
  import gpp_pkg::*;

  logic      accept, cmd_push, cmd_full, cmd_empty, cmd_pop;
  logic      res_push, res_full;
  cmd_t      cmd_in, cmd_out;
  out_word_t res;

  assign accept  = in_push && !in_full;
  assign in_full = cmd_full;

  gpp_front #(.MAX_PACKET_BYTES(MAX_PACKET_BYTES)) u_front (
    .clk(clk), .rst_n(rst_n), .accept(accept), .in_word(in_word),
    .cmd_push(cmd_push), .cmd(cmd_in)
  );

  gpp_fifo #(.WIDTH($bits(cmd_t)), .ADDR_W(2)) u_cmd_q (
    .clk(clk), .rst_n(rst_n), .push(cmd_push), .wdata(cmd_in), .full(cmd_full),
    .pop(cmd_pop), .rdata(cmd_out), .empty(cmd_empty)
  );

  gpp_back #(.PEER_SLOTS(PEER_SLOTS)) u_back (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .cmd(cmd_out), .cmd_empty(cmd_empty), .cmd_pop(cmd_pop),
    .res_full(res_full), .res_push(res_push), .res(res)
  );

  gpp_fifo #(.WIDTH($bits(out_word_t)), .ADDR_W(1)) u_res_q (
    .clk(clk), .rst_n(rst_n), .push(res_push), .wdata(res), .full(res_full),
    .pop(out_pop), .rdata(out_word), .empty(out_empty)
  );
endmodule

FILE: dv/tempo_gossip_packet_parser_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tempo_gossip_packet_parser_core_tb
// drives gossip packets, expiry ticks and endpoint queries through the parser
// and checks every result word against a cycle-free model of the session
// state and peer table; lifetime changes only while the core is idle
// ----------------------------------------------------------------------------
module tempo_gossip_packet_parser_core_tb;
  import gpp_pkg::*;

  class parser_scoreboard;
    logic [19:0] lifetime;
    logic [63:0] ids [8];
    logic [31:0] expiry [8];
    logic [31:0] ip [8];
    logic [15:0] port [8];
    bit          has_ep [8];
    int unsigned total;
    logic [41:0] tempo;
    bit          playing;
    bit          seen;
    int unsigned pos;
    bit          hdr_ok;
    logic [7:0]  kind;
    logic [63:0] sender;
    logic [31:0] rkey;
    logic [31:0] rsize;
    logic [31:0] roff;
    logic [63:0] cap;
    out_word_t   expected_q [$];
    int          errors;
    int          checked;
    int          accepted_pkts;

    function new();
      lifetime = LIFETIME_RESET;
      total = 0;
      tempo = '0;
      playing = 0;
      seen = 0;
      errors = 0;
      checked = 0;
      accepted_pkts = 0;
      restart();
    endfunction

    function void restart();
      pos = 0;
      hdr_ok = 1;
      kind = '0;
      sender = '0;
      rkey = '0;
      rsize = '0;
      roff = '0;
      cap = '0;
    endfunction

    function int find(logic [63:0] id);
      for (int i = 0; i < total; i++)
        if (ids[i] == id) return i;
      return -1;
    endfunction

    function void drop_slot(int d);
      int src;
      src = total - 1;
      ids[d] = ids[src];
      expiry[d] = expiry[src];
      ip[d] = ip[src];
      port[d] = port[src];
      has_ep[d] = has_ep[src];
      total = src;
    endfunction

    function void clear_if_empty();
      if (total == 0) begin
        tempo = '0;
        playing = 0;
        seen = 0;
      end
    endfunction

    function void header_end(logic [31:0] now);
      int s;
      if (!hdr_ok) return;
      s = find(sender);
      if (kind == KIND_BYE) begin
        if (s >= 0) begin
          drop_slot(s);
          clear_if_empty();
        end
      end else if (kind == KIND_ALIVE || kind == KIND_RESPONSE) begin
        if (s < 0 && total < 8) begin
          s = total;
          ids[s] = sender;
          ip[s] = '0;
          port[s] = '0;
          has_ep[s] = 0;
          total++;
        end
        if (s >= 0) expiry[s] = now + 32'(lifetime);
      end
    endfunction

    function void apply_rec();
      int unsigned n;
      int s;
      logic [63:0] sh;
      n = (rsize < 8) ? rsize : 8;
      if (rkey == KEY_TEMPO && rsize >= 8 && cap != 0 && !cap[63])
        tempo = 42'(64'd3932160000000 / cap);
      if (rkey == KEY_ENDPOINT && rsize >= 6) begin
        s = find(sender);
        if (s >= 0) begin
          sh = cap >> (8 * (n - 4));
          ip[s] = sh[31:0];
          sh = cap >> (8 * (n - 6));
          port[s] = sh[15:0];
          has_ep[s] = 1;
        end
      end
      if (rkey == KEY_STST && rsize >= 1) begin
        sh = cap >> (8 * (n - 1));
        playing = (sh[7:0] != 0);
        seen = 1;
      end
    endfunction

    function void take_byte(logic [7:0] b, logic [31:0] now);
      if (pos >= 65535) return;
      if (pos < 8) begin
        if (b != SIG[pos]) hdr_ok = 0;
      end else if (pos == 8) begin
        kind = b;
      end else if (pos >= 12 && pos < HEADER_LEN) begin
        sender = {sender[55:0], b};
        if (pos == HEADER_LEN - 1) header_end(now);
      end else if (pos >= HEADER_LEN && hdr_ok &&
                   (kind == KIND_ALIVE || kind == KIND_RESPONSE)) begin
        if (roff < 4) rkey = {rkey[23:0], b};
        else if (roff < 8) rsize = {rsize[23:0], b};
        else if (roff - 8 < 8) cap = {cap[55:0], b};
        roff++;
        if (roff >= 8 && {32'd0, roff} == 64'd8 + {32'd0, rsize}) begin
          apply_rec();
          roff = '0;
          rkey = '0;
          rsize = '0;
          cap = '0;
        end
      end
      pos++;
    endfunction

    function void note_input(in_word_t w);
      out_word_t e;
      int i;
      e = '0;
      if (w.operation == OP_BYTE) begin
        take_byte(w.data_byte, w.now_ms);
        if (!w.end_of_packet) return;
        e.packet_accepted = (pos >= HEADER_LEN && hdr_ok && kind >= KIND_ALIVE
                             && kind <= KIND_BYE);
        if (e.packet_accepted) accepted_pkts++;
        restart();
      end else if (w.operation == OP_TICK) begin
        i = 0;
        while (i < total) begin
          if (((w.now_ms - expiry[i]) & 32'h8000_0000) == 0) drop_slot(i);
          else i++;
        end
        clear_if_empty();
      end else if (w.operation == OP_QUERY) begin
        if (w.peer_index < total && has_ep[w.peer_index]) begin
          e.endpoint_valid = 1;
          e.endpoint_ip = ip[w.peer_index];
          e.endpoint_port = port[w.peer_index];
        end
      end else begin
        return;
      end
      e.bpm_q16 = tempo;
      e.playing = playing;
      e.start_stop_seen = seen;
      e.peer_count = 4'(total);
      expected_q.push_back(e);
    endfunction

    function void report(string field, logic [63:0] exp_v, logic [63:0] act_v);
      if (exp_v !== act_v) begin
        errors++;
        $display("%0t: %s mismatch, expected %0h actual %0h", $time, field, exp_v, act_v);
      end
    endfunction

    function void check(out_word_t got);
      out_word_t e;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result word, expected none actual %0h", $time, got);
        return;
      end
      e = expected_q.pop_front();
      checked++;
      report("packet_accepted", e.packet_accepted, got.packet_accepted);
      report("bpm_q16", e.bpm_q16, got.bpm_q16);
      report("playing", e.playing, got.playing);
      report("start_stop_seen", e.start_stop_seen, got.start_stop_seen);
      report("peer_count", e.peer_count, got.peer_count);
      report("endpoint_valid", e.endpoint_valid, got.endpoint_valid);
      report("endpoint_ip", e.endpoint_ip, got.endpoint_ip);
      report("endpoint_port", e.endpoint_port, got.endpoint_port);
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_push;
  logic        in_full;
  in_word_t    in_word;
  logic        out_empty;
  logic        out_pop;
  out_word_t   out_word;
  logic        cfg_we;
  logic [19:0] cfg_wdata;

  parser_scoreboard sb;
  int          idle_in;
  int          idle_out;
  int          stall;
  int          words_sent;
  logic [31:0] clock_ms;
  logic [19:0] life_ms;
  logic [63:0] id_pool [12];
  logic [7:0]  pkt [$];

  tempo_gossip_packet_parser_core DUT (
    .clk(clk), .rst_n(rst_n),
    .in_push(in_push), .in_full(in_full), .in_word(in_word),
    .out_empty(out_empty), .out_pop(out_pop), .out_word(out_word),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      stall   <= 0;
      out_pop <= 1'b0;
    end else begin
      if (in_push && !in_full) sb.note_input(in_word);
      if (out_pop && !out_empty) sb.check(out_word);
      if ((in_push && !in_full) || (out_pop && !out_empty)) begin
        stall <= 0;
      end else if (stall >= 20000) begin
        $display("watchdog: no progress for %0d cycles", stall);
        $display("Testbench completed WITH ERRORS");
        $finish;
      end else begin
        stall <= stall + 1;
      end
      out_pop <= ($urandom_range(99) >= idle_out);
    end
  end

  task automatic send(input in_word_t w);
    while ($urandom_range(99) < idle_in) begin
      in_push <= 1'b0;
      @(posedge clk);
    end
    in_push <= 1'b1;
    in_word <= w;
    words_sent++;
    do @(posedge clk); while (in_full);
  endtask

  function automatic in_word_t rand_word(logic [1:0] op);
    in_word_t w;
    logic [63:0] r;
    r = {$urandom, $urandom};
    w = r[$bits(in_word_t)-1:0];
    w.operation = op;
    return w;
  endfunction

  task automatic send_tick(input logic [31:0] now);
    in_word_t w;
    w = rand_word(OP_TICK);
    w.now_ms = now;
    send(w);
  endtask

  task automatic send_query(input logic [2:0] idx);
    in_word_t w;
    w = rand_word(OP_QUERY);
    w.peer_index = idx;
    send(w);
  endtask

  task automatic send_packet(input bit mix);
    in_word_t w;
    int r;
    for (int i = 0; i < pkt.size(); i++) begin
      if (mix) begin
        r = $urandom_range(999);
        if (r < 15) send_tick(clock_ms + $urandom_range(0, 32'(life_ms) / 2));
        else if (r < 35) send_query(3'($urandom_range(7)));
        else if (r < 40) send(rand_word(OP_SPARE));
      end
      w = rand_word(OP_BYTE);
      w.data_byte = pkt[i];
      w.end_of_packet = (i == pkt.size() - 1);
      w.now_ms = clock_ms;
      send(w);
    end
  endtask

  function automatic void put32(logic [31:0] v);
    for (int i = 3; i >= 0; i--) pkt.push_back(v[8*i +: 8]);
  endfunction

  function automatic void start_pkt(logic [7:0] kind, logic [63:0] id);
    pkt.delete();
    for (int i = 0; i < 8; i++) pkt.push_back(SIG[i]);
    pkt.push_back(kind);
    put32({8'($urandom), 8'($urandom), 8'($urandom), 8'h00});
    pkt.pop_back();
    put32(id[63:32]);
    put32(id[31:0]);
  endfunction

  function automatic void add_record(logic [31:0] key, int unsigned size, logic [63:0] val);
    put32(key);
    put32(size);
    for (int i = 0; i < size; i++)
      pkt.push_back((i < 8) ? val[8*(7-i) +: 8] : 8'($urandom));
  endfunction

  function automatic logic [63:0] rand_micros();
    int r;
    r = $urandom_range(9);
    if (r == 0) return 64'd0;
    if (r == 1) return {1'b1, 63'($urandom)} | 64'($urandom);
    if (r == 2) return 64'd1;
    if (r == 3) return {1'b0, {31{1'b1}}, 32'($urandom)};
    return 64'($urandom_range(2000000, 150000));
  endfunction

  function automatic void build_random_pkt();
    int r;
    int nrec;
    logic [63:0] v;
    logic [7:0] k;
    r = $urandom_range(99);
    k = ($urandom_range(1)) ? KIND_RESPONSE : KIND_ALIVE;
    start_pkt((r < 80) ? k : KIND_BYE, id_pool[$urandom_range(11)]);
    if (r < 80) begin
      nrec = $urandom_range(3);
      for (int j = 0; j < nrec; j++) begin
        v = {$urandom, $urandom};
        case ($urandom_range(3))
          0: add_record(KEY_TEMPO, 8 + (($urandom_range(3) == 0) ? $urandom_range(3) : 0),
                        rand_micros());
          1: add_record(KEY_ENDPOINT, ($urandom_range(1)) ? 6 : $urandom_range(10, 5), v);
          2: begin
            if ($urandom_range(1)) v[63:56] = 8'h00;
            add_record(KEY_STST, $urandom_range(3, 0), v);
          end
          default: add_record($urandom, $urandom_range(5), v);
        endcase
      end
    end
    // noise: broken signature, bad kind, short or cut packets
    r = $urandom_range(99);
    if (r < 5) pkt[$urandom_range(7)] ^= 8'(1 << $urandom_range(7));
    else if (r < 9) pkt[8] = ($urandom_range(1)) ? 8'd0 : 8'($urandom_range(255, 4));
    else if (r < 13) pkt = pkt[0:$urandom_range(18)];
    else if (r < 17 && pkt.size() > 22) pkt = pkt[0:$urandom_range(pkt.size() - 2, 20)];
  endfunction

  task automatic write_lifetime(input logic [19:0] v);
    in_push <= 1'b0;
    @(posedge clk);
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (120) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.lifetime = v;
    life_ms = v;
  endtask

  task automatic directed();
    logic [63:0] id;
    id = id_pool[0];
    start_pkt(KIND_ALIVE, id);
    add_record(KEY_TEMPO, 8, 64'd1);
    add_record(KEY_ENDPOINT, 6, 64'hFFFF_FFFF_FFFF_0000);
    add_record(KEY_STST, 1, 64'h0100_0000_0000_0000);
    send_packet(0);
    send_query(3'd0);
    send_query(3'd7);
    start_pkt(KIND_RESPONSE, id_pool[1]);
    add_record(KEY_TEMPO, 8, 64'h7FFF_FFFF_FFFF_FFFF);
    add_record(KEY_TEMPO, 8, 64'hFFFF_FFFF_FFFF_FFFF);
    add_record(KEY_STST, 2, 64'h0000_0000_0000_0000);
    send_packet(0);
    start_pkt(KIND_BYE, id_pool[1]);
    send_packet(0);
    send(rand_word(OP_SPARE));
    send_tick(clock_ms + 32'(life_ms));
    send_query(3'd0);
  endtask

  initial begin
    int life_set [5];
    int target;
    sb = new();
    rst_n = 0;
    in_push = 0;
    in_word = '0;
    cfg_we = 0;
    cfg_wdata = '0;
    words_sent = 0;
    idle_in = 21;
    idle_out = 62;
    life_ms = LIFETIME_RESET;
    clock_ms = $urandom;
    foreach (id_pool[i]) id_pool[i] = {$urandom, $urandom};
    life_set = '{0, 1, 600000, 20'hFFFFF, $urandom_range(600000, 1)};
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    directed();
    for (int seg = 0; seg < 5; seg++) begin
      write_lifetime(20'(life_set[seg]));
      idle_in = (seg < 2) ? 21 : (seg < 4) ? 62 : 0;
      idle_out = (seg < 2) ? 62 : (seg < 4) ? 21 : 0;
      target = words_sent + 140;
      while (words_sent < target) begin
        build_random_pkt();
        send_packet(1);
        clock_ms += $urandom_range(0, 32'(life_ms) / 3 + 1);
        if ($urandom_range(3) == 0) send_tick(clock_ms);
      end
    end
    in_push <= 1'b0;
    @(posedge clk);
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (120) @(posedge clk);
    $display("sent %0d words, checked %0d results, %0d packets accepted",
             words_sent, sb.checked, sb.accepted_pkts);
    $display("lifetimes 0, 1, 600000, max and random, with sender and receiver stalls");
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule
